// ===== hw/rtl/b64sc_pkg.sv =====
// Shared types, constants and alphabet functions for the base64 stream codec.
`default_nettype none
package b64sc_pkg;

  localparam int BUF_W   = 12;
  localparam int CNT_W   = 4;
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_BITS = 2'd3
  } status_t;

  // One input item's worth of results, as queued between front and back.
  typedef struct packed {
    logic [SLOT_W-1:0]      last_idx;
    logic                   no_data;
    logic                   msg_end;
    status_t                status;
    logic [SLOTS-1:0][7:0]  vals;
  } grp_t;

  // Alphabet index of an ASCII code; bit 6 set when the code is in the alphabet.
  function automatic logic [6:0] sym_index(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // ASCII character for a six-bit alphabet index.
  function automatic logic [7:0] sym_char(input logic [5:0] i);
    logic [7:0] r;
    logic [7:0] w;
    w = {2'b00, i};
    if (i < 6'd26) begin
      r = w + 8'h41;
    end else if (i < 6'd52) begin
      r = w + 8'd71;
    end else if (i < 6'd62) begin
      r = w - 8'd4;
    end else if (i == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/base64_stream_codec.sv =====
// Top level of the streaming base64 encoder/decoder.
// Each item's results are registered into the queue as the item is accepted.
// Throughput: one item per cycle while the two-group queue has room; results leave
// one per cycle while the receiver pops, so when encoding, four symbols per three bytes limit the rate.
// Reset: synchronous; clears message state and queue and selects encode.
`default_nettype none
module base64_stream_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_value,
  input  wire logic        has_value,
  input  wire logic        end_of_message,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_value,
  output logic             out_has_value,
  output logic             run_last,
  output logic             message_end,
  output logic [1:0]       status,
  input  wire logic        direction_we,
  input  wire logic        direction
);

  b64sc_pkg::grp_t  q_wdata;
  b64sc_pkg::grp_t  q_rdata;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  assign full = q_full;

  b64sc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .in_value       (in_value),
    .has_value      (has_value),
    .end_of_message (end_of_message),
    .direction_we   (direction_we),
    .direction      (direction),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  b64sc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  b64sc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_value     (out_value),
    .out_has_value (out_has_value),
    .run_last      (run_last),
    .message_end   (message_end),
    .status        (status)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/b64sc_front.sv =====
// Front end: accepts items, tracks message state and builds each item's result group.
`default_nettype none
module b64sc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [7:0]         in_value,
  input  wire logic               has_value,
  input  wire logic               end_of_message,
  input  wire logic               direction_we,
  input  wire logic               direction,
  input  wire logic               q_full,
  output logic                    q_push,
  output b64sc_pkg::grp_t         q_data
);

  logic                              dir;
  logic [b64sc_pkg::BUF_W-1:0]       bbuf, bbuf_next;
  logic [b64sc_pkg::CNT_W-1:0]       bcnt, bcnt_next;
  logic [1:0]                        phase, phase_next;
  logic [1:0]                        padc, padc_next;
  logic                              pseen, pseen_next;
  b64sc_pkg::status_t                err, err_next;

  logic                              accept;
  logic [b64sc_pkg::BUF_W-1:0]       buf_a;
  logic [b64sc_pkg::CNT_W-1:0]       cnt_a;
  logic [1:0]                        phase_a;
  logic [1:0]                        padc_a;
  logic                              pseen_a;
  b64sc_pkg::status_t                err_a;
  logic [2:0]                        n_tot;
  b64sc_pkg::grp_t                   grp;

  // encode temporaries
  logic [b64sc_pkg::BUF_W-1:0]       b8;
  logic [b64sc_pkg::CNT_W-1:0]       c8;
  logic [5:0]                        d0, d1, f0;
  logic [1:0]                        nd;
  logic                              fl;
  logic [1:0]                        phase_f, pads;
  logic [3:0]                        n_sum;
  // decode temporaries
  logic [6:0]                        lk;
  logic [b64sc_pkg::BUF_W-1:0]       b6;
  logic [b64sc_pkg::CNT_W-1:0]       c6;
  logic [7:0]                        dbyte;
  logic                              emit;
  logic                              pads_ok;

  assign accept = push & ~q_full;

  always_comb begin
    buf_a   = bbuf;
    cnt_a   = bcnt;
    phase_a = phase;
    padc_a  = padc;
    pseen_a = pseen;
    err_a   = err;
    n_tot   = 3'd0;
    b8      = {bbuf[3:0], in_value};
    c8      = bcnt + 4'd8;
    d0      = 6'd0;
    d1      = 6'd0;
    f0      = 6'd0;
    nd      = 2'd0;
    fl      = 1'b0;
    phase_f = 2'd0;
    pads    = 2'd0;
    n_sum   = 4'd0;
    lk      = b64sc_pkg::sym_index(in_value);
    b6      = {bbuf[5:0], lk[5:0]};
    c6      = bcnt + 4'd6;
    dbyte   = 8'd0;
    emit    = 1'b0;
    pads_ok = 1'b0;
    grp     = '0;
    grp.status = b64sc_pkg::ST_OK;

    if (!dir) begin
      if (has_value) begin
        case (c8)
          4'd12: begin
            d0 = b8[11:6];
            d1 = b8[5:0];
            nd = 2'd2;
            buf_a = '0;
            cnt_a = 4'd0;
          end
          4'd10: begin
            d0 = b8[9:4];
            nd = 2'd1;
            buf_a = {8'd0, b8[3:0]};
            cnt_a = 4'd4;
          end
          default: begin
            d0 = b8[7:2];
            nd = 2'd1;
            buf_a = {10'd0, b8[1:0]};
            cnt_a = 4'd2;
          end
        endcase
      end
      phase_a = phase + nd;
      if (end_of_message) begin
        case (cnt_a)
          4'd2: begin
            fl = 1'b1;
            f0 = {buf_a[1:0], 4'd0};
          end
          4'd4: begin
            fl = 1'b1;
            f0 = {buf_a[3:0], 2'd0};
          end
          default: fl = 1'b0;
        endcase
      end
      phase_f = phase_a + {1'b0, fl};
      pads    = end_of_message ? (2'd0 - phase_f) : 2'd0;
      n_sum   = {2'b00, nd} + {3'b000, fl} + {2'b00, pads};
      n_tot   = (n_sum > 4'd4) ? 3'd4 : n_sum[2:0];
      for (int k = 0; k < b64sc_pkg::SLOTS; k++) begin
        if (k < int'(nd)) begin
          grp.vals[k] = b64sc_pkg::sym_char((k == 0) ? d0 : d1);
        end else if (k < int'(nd) + int'(fl)) begin
          grp.vals[k] = b64sc_pkg::sym_char(f0);
        end else begin
          grp.vals[k] = b64sc_pkg::PAD_CHAR;
        end
      end
    end else begin
      if (has_value && err == b64sc_pkg::ST_OK) begin
        if (in_value == b64sc_pkg::PAD_CHAR) begin
          pseen_a = 1'b1;
          padc_a  = (padc == 2'd3) ? padc : padc + 2'd1;
          phase_a = phase + 2'd1;
        end else if (!lk[6]) begin
          err_a = b64sc_pkg::ST_BAD_CHAR;
        end else if (pseen) begin
          err_a = b64sc_pkg::ST_BAD_PAD;
        end else begin
          phase_a = phase + 2'd1;
          case (c6)
            4'd8: begin
              emit  = 1'b1;
              dbyte = b6[7:0];
              buf_a = '0;
              cnt_a = 4'd0;
            end
            4'd10: begin
              emit  = 1'b1;
              dbyte = b6[9:2];
              buf_a = {10'd0, b6[1:0]};
              cnt_a = 4'd2;
            end
            4'd12: begin
              emit  = 1'b1;
              dbyte = b6[11:4];
              buf_a = {8'd0, b6[3:0]};
              cnt_a = 4'd4;
            end
            default: begin
              buf_a = b6;
              cnt_a = c6;
            end
          endcase
        end
      end
      if (end_of_message && err_a == b64sc_pkg::ST_OK) begin
        pads_ok = (cnt_a == 4'd0 && padc_a == 2'd0) ||
                  (cnt_a == 4'd4 && padc_a == 2'd2) ||
                  (cnt_a == 4'd2 && padc_a == 2'd1);
        if (phase_a != 2'd0 || !pads_ok) begin
          err_a = b64sc_pkg::ST_BAD_PAD;
        end else if (buf_a != '0) begin
          err_a = b64sc_pkg::ST_BAD_BITS;
        end
      end
      n_tot = {2'b00, emit};
      grp.vals[0] = dbyte;
      grp.status  = err_a;
    end

    grp.no_data  = (n_tot == 3'd0);
    grp.msg_end  = end_of_message;
    grp.last_idx = (n_tot == 3'd0) ? '0 : b64sc_pkg::SLOT_W'(n_tot - 3'd1);
    if (!end_of_message) begin
      grp.status = b64sc_pkg::ST_OK;
    end
  end

  assign q_push = accept & (end_of_message | (n_tot != 3'd0));
  assign q_data = grp;

  // Message end or a direction write drops all message state.
  always_comb begin
    bbuf_next  = bbuf;
    bcnt_next  = bcnt;
    phase_next = phase;
    padc_next  = padc;
    pseen_next = pseen;
    err_next   = err;
    if (direction_we || (accept && end_of_message)) begin
      bbuf_next  = '0;
      bcnt_next  = '0;
      phase_next = '0;
      padc_next  = '0;
      pseen_next = 1'b0;
      err_next   = b64sc_pkg::ST_OK;
    end else if (accept) begin
      bbuf_next  = buf_a;
      bcnt_next  = cnt_a;
      phase_next = phase_a;
      padc_next  = padc_a;
      pseen_next = pseen_a;
      err_next   = err_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir   <= 1'b0;
      bbuf  <= '0;
      bcnt  <= '0;
      phase <= '0;
      padc  <= '0;
      pseen <= 1'b0;
      err   <= b64sc_pkg::ST_OK;
    end else begin
      if (direction_we) begin
        dir <= direction;
      end
      bbuf  <= bbuf_next;
      bcnt  <= bcnt_next;
      phase <= phase_next;
      padc  <= padc_next;
      pseen <= pseen_next;
      err   <= err_next;
    end
  end

  a_enc_cnt: assert property (@(posedge clk) disable iff (rst)
    !dir |-> (bcnt == 4'd0 || bcnt == 4'd2 || bcnt == 4'd4))
    else $error("encoder bit count off its 0/2/4 cycle");

  a_dec_cnt: assert property (@(posedge clk) disable iff (rst)
    dir |-> (bcnt == 4'd0 || bcnt == 4'd2 || bcnt == 4'd4 || bcnt == 4'd6))
    else $error("decoder bit count off its even cycle");

endmodule
`default_nettype wire

// ===== hw/rtl/b64sc_queue.sv =====
// Short register queue of result groups between the front and back ends.
`default_nettype none
module b64sc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire b64sc_pkg::grp_t wr_data,
  input  wire logic            rd_en,
  output b64sc_pkg::grp_t      rd_data,
  output logic                 full,
  output logic                 empty
);

  b64sc_pkg::grp_t                  mem [b64sc_pkg::QDEPTH];
  logic [b64sc_pkg::QPTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [b64sc_pkg::QPTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [b64sc_pkg::QCNT_W-1:0]     count, count_next;
  logic                             do_wr, do_rd;

  assign full    = (count == b64sc_pkg::QCNT_W'(b64sc_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_wr) begin
      wr_ptr_next = (wr_ptr == b64sc_pkg::QPTR_W'(b64sc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_next = (rd_ptr == b64sc_pkg::QPTR_W'(b64sc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_next = count + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= b64sc_pkg::QCNT_W'(b64sc_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");

endmodule
`default_nettype wire

// ===== hw/rtl/b64sc_back.sv =====
// Back end: steps through the head group and presents one result per transfer.
`default_nettype none
module b64sc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64sc_pkg::grp_t   head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             out_value,
  output logic                   out_has_value,
  output logic                   run_last,
  output logic                   message_end,
  output logic [1:0]             status
);

  logic [b64sc_pkg::SLOT_W-1:0]  idx, idx_next;
  logic                          xfer;
  logic                          at_last;

  assign empty   = q_empty;
  assign xfer    = pop & ~q_empty;
  assign at_last = (idx == head.last_idx);
  assign q_pop   = xfer & at_last;

  assign out_value     = head.no_data ? 8'd0 : head.vals[idx];
  assign out_has_value = ~head.no_data;
  assign run_last      = at_last;
  assign message_end   = at_last & head.msg_end;
  assign status        = message_end ? head.status : b64sc_pkg::ST_OK;

  // Advance within the group; wrap to the first slot when the group leaves.
  always_comb begin
    idx_next = idx;
    if (xfer) begin
      idx_next = at_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= head.last_idx)
    else $error("slot index past end of group");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (xfer && !at_last) |=> idx == $past(idx) + 1'b1)
    else $error("slot index did not advance on transfer");

endmodule
`default_nettype wire

// ===== tb/base64_stream_codec_tb.sv =====
// Self-checking testbench for the streaming base64 encoder/decoder.
`timescale 1ns / 1ps

module base64_stream_codec_tb;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 120;

  typedef struct packed {
    logic [7:0]          value;
    logic                has_data;
    logic                last;
    logic                msg_end;
    b64sc_pkg::status_t  st;
  } codec_result_t;

  // Tracks codec state, predicts the results of each accepted item and checks them in order.
  class codec_scoreboard;
    bit                  dir;
    int unsigned         bits;
    int unsigned         nbits;
    int unsigned         phase;
    int unsigned         pads;
    bit                  pad_seen;
    b64sc_pkg::status_t  err;
    codec_result_t       item_outputs[$];
    codec_result_t       awaited[$];
    int                  errors;
    int                  checked;

    function new();
      dir = 1'b0;
      errors = 0;
      checked = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      bits = 0;
      nbits = 0;
      phase = 0;
      pads = 0;
      pad_seen = 1'b0;
      err = b64sc_pkg::ST_OK;
    endfunction

    function void set_direction(bit d);
      dir = d;
      clear_msg();
    endfunction

    function int unsigned low_bits(int unsigned n);
      return (n >= 12) ? 32'hFFF : ((32'd1 << n) - 1);
    endfunction

    function int letter_index(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (B64_ALPHABET[i] == c) return i;
      end
      return -1;
    endfunction

    function void add_output(logic [7:0] v, bit h);
      codec_result_t r;
      if (item_outputs.size() >= 4) return;
      r.value = h ? v : 8'h00;
      r.has_data = h;
      r.last = 1'b0;
      r.msg_end = 1'b0;
      r.st = b64sc_pkg::ST_OK;
      item_outputs.insert(item_outputs.size(), r);
    endfunction

    function void note_input(logic [7:0] v, bit h, bit eom);
      int                  idx;
      bit                  pads_ok;
      b64sc_pkg::status_t  st;
      st = b64sc_pkg::ST_OK;
      item_outputs.delete();
      if (!dir) begin
        if (h) begin
          bits = ((bits << 8) | v) & 32'hFFF;
          nbits += 8;
          while (nbits >= 6) begin
            nbits -= 6;
            add_output(B64_ALPHABET[(bits >> nbits) & 63], 1'b1);
            phase = (phase + 1) & 3;
          end
          bits &= low_bits(nbits);
        end
        if (eom) begin
          // zero-fill the leftover bits into one more symbol, then pad to a quad
          if (nbits > 0 && nbits < 6) begin
            add_output(B64_ALPHABET[(bits << (6 - nbits)) & 63], 1'b1);
            phase = (phase + 1) & 3;
          end
          while (phase != 0) begin
            add_output(b64sc_pkg::PAD_CHAR, 1'b1);
            phase = (phase + 1) & 3;
          end
        end
      end else begin
        if (h && err == b64sc_pkg::ST_OK) begin
          if (v == b64sc_pkg::PAD_CHAR) begin
            pad_seen = 1'b1;
            if (pads < 3) pads++;
            phase = (phase + 1) & 3;
          end else begin
            idx = letter_index(v);
            if (idx < 0) begin
              err = b64sc_pkg::ST_BAD_CHAR;
            end else if (pad_seen) begin
              err = b64sc_pkg::ST_BAD_PAD;
            end else begin
              bits = ((bits << 6) | idx) & 32'hFFF;
              nbits += 6;
              phase = (phase + 1) & 3;
              if (nbits >= 8) begin
                nbits -= 8;
                add_output((bits >> nbits) & 255, 1'b1);
              end
              bits &= low_bits(nbits);
            end
          end
        end
        if (eom && err == b64sc_pkg::ST_OK) begin
          pads_ok = (nbits == 0 && pads == 0) || (nbits == 4 && pads == 2) ||
                    (nbits == 2 && pads == 1);
          if (phase != 0 || !pads_ok) begin
            err = b64sc_pkg::ST_BAD_PAD;
          end else if ((bits & low_bits(nbits)) != 0) begin
            err = b64sc_pkg::ST_BAD_BITS;
          end
        end
        st = err;
      end
      if (eom) begin
        if (item_outputs.size() == 0) add_output(8'h00, 1'b0);
        item_outputs[$].msg_end = 1'b1;
        item_outputs[$].st = st;
        clear_msg();
      end
      if (item_outputs.size() > 0) item_outputs[$].last = 1'b1;
      foreach (item_outputs[i]) awaited.insert(awaited.size(), item_outputs[i]);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_output(codec_result_t got);
      codec_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result value=%02h", got.value));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.value !== want.value)
        report($sformatf("out_value got %02h want %02h", got.value, want.value));
      if (got.has_data !== want.has_data)
        report($sformatf("out_has_value got %0b want %0b", got.has_data, want.has_data));
      if (got.last !== want.last)
        report($sformatf("run_last got %0b want %0b", got.last, want.last));
      if (got.msg_end !== want.msg_end)
        report($sformatf("message_end got %0b want %0b", got.msg_end, want.msg_end));
      if (got.st !== want.st)
        report($sformatf("status got %0d want %0d", got.st, want.st));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_value = 8'h00;
  logic       has_value = 1'b0;
  logic       end_of_message = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_value;
  logic       out_has_value;
  logic       run_last;
  logic       message_end;
  logic [1:0] status;
  logic       direction_we = 1'b0;
  logic       direction = 1'b0;

  codec_scoreboard sb;
  int burst_left = 0;
  bit steady = 1'b0;
  int items_sent = 0;
  int msgs_sent = 0;
  int dir_writes = 0;
  int stall_cycles = 0;
  int rx_tick = 0;
  int rx_mode = 0;

  base64_stream_codec DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_value(in_value),
    .has_value(has_value),
    .end_of_message(end_of_message),
    .empty(empty),
    .pop(pop),
    .out_value(out_value),
    .out_has_value(out_has_value),
    .run_last(run_last),
    .message_end(message_end),
    .status(status),
    .direction_we(direction_we),
    .direction(direction)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver stall pattern: pop follows a mode that is redrawn at random as rx_tick runs.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 63) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: pop <= !rst;
      1: pop <= !rst && ($urandom_range(0, 1) == 1);
      2: pop <= !rst && (rx_tick % 4 == 0);
      default: pop <= !rst && (rx_tick % 8 >= 6);
    endcase
  end

  always @(posedge clk) begin : result_check
    codec_result_t seen;
    if (!rst && pop && !empty) begin
      seen.value = out_value;
      seen.has_data = out_has_value;
      seen.last = run_last;
      seen.msg_end = message_end;
      seen.st = b64sc_pkg::status_t'(status);
      sb.check_output(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("[base64_stream_codec] ERROR");
    $finish;
  end

  // Present one item and hold it until the transfer happens.
  task automatic send_item(input logic [7:0] v, input logic h, input logic e);
    push = 1'b1;
    in_value = v;
    has_value = h;
    end_of_message = e;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(v, h, e);
    @(negedge clk);
  endtask

  // Send in bursts of random length with random gaps, with gap-free stretches.
  task automatic deliver(input logic [7:0] v, input logic h, input logic e);
    int gap;
    send_item(v, h, e);
    items_sent++;
    if (e) msgs_sent++;
    if ($urandom_range(0, 15) == 0) steady = !steady;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = steady ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
  endtask

  task automatic send_text(input string s, input bit eom_on_last);
    for (int i = 0; i < s.len(); i++) begin
      deliver(s[i], 1'b1, eom_on_last && (i == s.len() - 1));
    end
  endtask

  // Hold input until every awaited result has drained, then let the pipe settle.
  task automatic wait_drain();
    push = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_direction(input bit d);
    wait_drain();
    direction_we = 1'b1;
    direction = d;
    @(negedge clk);
    direction_we = 1'b0;
    sb.set_direction(d);
    dir_writes++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic encode_message();
    int n;
    bit sep;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 5);
    sep = (n == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) deliver(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      deliver(pick_byte(), 1'b1, !sep && (i == n - 1));
    end
    if (sep) deliver(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic decode_message();
    logic [7:0] text[$];
    int kind;
    int quads;
    int tail;
    bit sep;
    kind = $urandom_range(0, 9);
    quads = $urandom_range(0, 2);
    tail = $urandom_range(0, 2);
    if (kind == 9) begin
      // noise: mix of pads, letters and arbitrary bytes
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: text.insert(text.size(), b64sc_pkg::PAD_CHAR);
          1: text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63)]);
          default: text.insert(text.size(), 8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      repeat (quads * 4) text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63)]);
      if (tail == 1) begin
        text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63)]);
        text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63) & 6'h30]);
        text.insert(text.size(), b64sc_pkg::PAD_CHAR);
        text.insert(text.size(), b64sc_pkg::PAD_CHAR);
      end else if (tail == 2) begin
        text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63)]);
        text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63)]);
        text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63) & 6'h3C]);
        text.insert(text.size(), b64sc_pkg::PAD_CHAR);
      end
      // break the well-formed text now and then
      if (kind == 6 && tail != 0) begin
        text[quads * 4 + tail] = B64_ALPHABET[$urandom_range(0, 63) | 1];
      end else if (kind == 7 && text.size() > 0) begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 8 && text.size() > 0) begin
        void'(text.pop_back());
      end
    end
    sep = (text.size() == 0) || ($urandom_range(0, 1) == 1);
    foreach (text[i]) begin
      if ($urandom_range(0, 7) == 0) deliver(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      deliver(text[i], 1'b1, !sep && (i == text.size() - 1));
    end
    if (sep) deliver(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int start_items;
    int phase_no;
    sb = new();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // encode: empty message, one and two byte tails, full group closed by a bare end
    deliver(8'h00, 1'b0, 1'b1);
    deliver(8'h00, 1'b1, 1'b1);
    deliver(8'hFF, 1'b1, 1'b0);
    deliver(8'hFF, 1'b1, 1'b1);
    deliver(8'h80, 1'b1, 1'b0);
    deliver(8'h7F, 1'b1, 1'b0);
    deliver(8'h01, 1'b1, 1'b0);
    deliver(8'hA5, 1'b0, 1'b0);
    deliver(8'h00, 1'b0, 1'b1);

    // decode: clean, unknown char, letter after pad, trailing bits, short length
    write_direction(1'b1);
    send_text("Zm8=", 1'b1);
    send_text("Q*", 1'b1);
    send_text("Q=Q=", 1'b1);
    send_text("QR==", 1'b1);
    send_text("QQ=", 1'b1);

    start_items = items_sent;
    phase_no = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      write_direction(phase_no[0]);
      repeat ($urandom_range(3, 6)) begin
        if (phase_no[0]) decode_message();
        else encode_message();
        if (phase_no == 2 && sb.awaited.size() != 0) wait_drain();
      end
      // leave a message unfinished so the next direction write must abandon it
      if (phase_no == 1 || $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) deliver(pick_byte(), 1'b1, 1'b0);
      end
      phase_no++;
    end

    push = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Run covered %0d items in %0d messages, %0d results checked, %0d direction writes.",
             items_sent, msgs_sent, sb.checked, dir_writes);
    $display("Both directions, padding and error cases, abandoned messages and stalls included.");
    if (sb.errors == 0) begin
      $display("[base64_stream_codec] OK");
    end else begin
      $display("[base64_stream_codec] ERROR");
    end
    $finish;
  end

endmodule
